// ----- sv/csem_pkg.sv -----
// shared types and constants of the counting semaphore table
`default_nettype none

package csem_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int ID_W              = 16;
    localparam int CNT_W             = 15;
    localparam int VAL_W             = 16;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_OPEN  = 2'd0,
        CMD_CLOSE = 2'd1,
        CMD_UP    = 2'd2,
        CMD_DOWN  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_VALUE   = 3'd1,
        ST_FULL        = 3'd2,
        ST_NOT_FOUND   = 3'd3,
        ST_WOULD_BLOCK = 3'd4,
        ST_SATURATED   = 3'd5
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } state_t;

    // one table entry as held in the memory
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] count;
    } entry_t;

    typedef struct packed {
        status_t          status;
        logic             wake;
        logic [ID_W-1:0]  wake_id;
        logic [CNT_W-1:0] count_after;
    } result_t;

    // table updates asked for by the execute logic
    typedef struct packed {
        logic wr_en;
        logic open_set;
        logic open_clr;
    } upd_t;

endpackage : csem_pkg

`default_nettype wire

// ----- sv/csem_ram.sv -----
// generic single-port-write, registered-read ram
`default_nettype none

module csem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : csem_ram

`default_nettype wire

// ----- sv/csem_exec.sv -----
// result and write-back logic for one resolved table operation
`default_nettype none

module csem_exec (
    input  wire csem_pkg::cmd_t             cmd,
    input  wire logic [csem_pkg::ID_W-1:0]  sem_id,
    input  wire logic [csem_pkg::CNT_W-1:0] init_count,
    input  wire logic                       bad_value,
    input  wire logic                       hit,
    input  wire csem_pkg::entry_t           rd_entry,
    output csem_pkg::result_t               result,
    output csem_pkg::upd_t                  upd,
    output csem_pkg::entry_t                wr_entry
);
    import csem_pkg::*;

    always_comb
    begin
        result         = '0;
        result.status  = ST_OK;
        upd            = '0;
        wr_entry.id    = sem_id;
        wr_entry.count = rd_entry.count;

        if (bad_value)
        begin
            result.status = ST_BAD_VALUE;
        end
        else if (!hit)
        begin
            result.status = (cmd == CMD_OPEN) ? ST_FULL : ST_NOT_FOUND;
        end
        else
        begin
            unique case (cmd)
                CMD_OPEN:
                begin
                    upd.open_set       = 1'b1;
                    upd.wr_en          = 1'b1;
                    wr_entry.count     = init_count;
                    result.count_after = init_count;
                end
                CMD_CLOSE:
                begin
                    upd.open_clr   = 1'b1;
                    result.wake    = 1'b1;
                    result.wake_id = sem_id;
                end
                CMD_UP:
                begin
                    if (rd_entry.count == COUNT_MAX)
                    begin
                        result.status      = ST_SATURATED;
                        result.count_after = rd_entry.count;
                    end
                    else
                    begin
                        upd.wr_en          = 1'b1;
                        wr_entry.count     = rd_entry.count + CNT_W'(1);
                        result.count_after = wr_entry.count;
                        if (rd_entry.count == '0)
                        begin
                            result.wake    = 1'b1;
                            result.wake_id = sem_id;
                        end
                    end
                end
                CMD_DOWN:
                begin
                    if (rd_entry.count == '0)
                    begin
                        result.status = ST_WOULD_BLOCK;
                    end
                    else
                    begin
                        upd.wr_en          = 1'b1;
                        wr_entry.count     = rd_entry.count - CNT_W'(1);
                        result.count_after = wr_entry.count;
                    end
                end
            endcase
        end
    end

endmodule : csem_exec

`default_nettype wire

// ----- sv/counting_semaphore_table_core.sv -----
// top level of the counting semaphore table
`default_nettype none

// A table of TABLE_ENTRIES counting semaphores. Each input word carries a
// command in tuser (open, close, up, down) and the semaphore id and initial
// count in tdata; each produces exactly one output word with a status, a
// wake flag plus the id to wake, and the count left in the addressed entry.
// Ids and counts live in one synchronous ram with a registered read; open
// flags sit in flip-flops cleared by reset, so the table is usable right
// after reset with no clearing pass. An operation scans entries in
// ascending order, one ram read per cycle, and stops at the first closed
// entry (open) or the first open entry with a matching id (others). An
// operation's result waits on this scan through the ram read port, except
// that a negative initial count is rejected without a ram read, and the
// core goes back to idle before the next word is taken. Only one
// operation is in flight, so the write-back of one never overlaps the
// reads of the next. The result sits in an output register, so a new word
// is accepted while the previous result is still waiting on tready.
module counting_semaphore_table_core #(
    parameter int TABLE_ENTRIES = csem_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // sem_id [15:0], init_value [31:16]
    input  wire logic [31:0] s_axis_tdata,
    // command [1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status [2:0], wake [3], wake_id [19:4], count_after [34:20], zero [39:35]
    output logic [39:0]      m_axis_tdata
);
    import csem_pkg::*;

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SCAN_W = $clog2(TABLE_ENTRIES + 1);
    localparam int ENT_W  = $bits(entry_t);

    // request held for the whole scan
    cmd_t                     cmd_reg,  cmd_next;
    logic [ID_W-1:0]          id_reg,   id_next;
    logic signed [VAL_W-1:0]  init_reg, init_next;

    state_t                   state_reg, state_next;

    // scan pointers: issue address and the entry whose data is in rdata
    logic [SCAN_W-1:0]        scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]         rd_idx_reg,   rd_idx_next;
    logic                     rd_valid_reg, rd_valid_next;

    logic [TABLE_ENTRIES-1:0] open_reg, open_next;

    logic                     out_valid_reg, out_valid_next;
    result_t                  out_reg, out_next;

    logic                     s_accept;
    logic                     out_free;
    logic                     issue;
    logic                     ram_re;
    logic                     is_open;
    logic                     hit;
    logic                     last;
    logic                     bad_value;
    logic                     done;
    logic                     fire;

    entry_t                   rd_entry;
    entry_t                   wr_entry;
    result_t                  result;
    upd_t                     upd;

    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    assign issue     = scan_idx_reg < SCAN_W'(TABLE_ENTRIES);
    assign is_open   = open_reg[rd_idx_reg];
    assign hit       = (cmd_reg == CMD_OPEN) ? !is_open
                                             : (is_open && rd_entry.id == id_reg);
    assign last      = rd_idx_reg == IDX_W'(TABLE_ENTRIES - 1);
    assign bad_value = (cmd_reg == CMD_OPEN) && init_reg[VAL_W-1];

    // done holds while stalled: no new read, so rdata stays put
    assign done      = (state_reg == S_SCAN)
                       && (bad_value || (rd_valid_reg && (hit || last)));
    assign fire      = done && out_free;
    assign ram_re    = (state_reg == S_SCAN) && issue && !done;

    csem_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (fire && upd.wr_en),
        .waddr (rd_idx_reg),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (rd_entry)
    );

    csem_exec u_exec (
        .cmd        (cmd_reg),
        .sem_id     (id_reg),
        .init_count (init_reg[CNT_W-1:0]),
        .bad_value  (bad_value),
        .hit        (hit),
        .rd_entry   (rd_entry),
        .result     (result),
        .upd        (upd),
        .wr_entry   (wr_entry)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        s_axis_tready  = (state_reg == S_IDLE);
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        init_next      = init_reg;
        scan_idx_next  = scan_idx_reg;
        rd_idx_next    = rd_idx_reg;
        rd_valid_next  = rd_valid_reg;
        open_next      = open_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    cmd_next      = cmd_t'(s_axis_tuser);
                    id_next       = s_axis_tdata[ID_W-1:0];
                    init_next     = s_axis_tdata[ID_W +: VAL_W];
                    scan_idx_next = '0;
                    rd_valid_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (ram_re)
                begin
                    rd_idx_next   = scan_idx_reg[IDX_W-1:0];
                    rd_valid_next = 1'b1;
                    scan_idx_next = scan_idx_reg + SCAN_W'(1);
                end
                if (fire)
                begin
                    rd_valid_next  = 1'b0;
                    out_next       = result;
                    out_valid_next = 1'b1;
                    if (upd.open_set)
                    begin
                        open_next[rd_idx_reg] = 1'b1;
                    end
                    if (upd.open_clr)
                    begin
                        open_next[rd_idx_reg] = 1'b0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_valid_reg  <= 1'b0;
            open_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_valid_next;
            open_reg      <= open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        id_reg       <= id_next;
        init_reg     <= init_next;
        scan_idx_reg <= scan_idx_next;
        rd_idx_reg   <= rd_idx_next;
        out_reg      <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_reg.count_after, out_reg.wake_id,
                            out_reg.wake, out_reg.status};

endmodule : counting_semaphore_table_core

`default_nettype wire

// ----- sv/csem_checker.sv -----
// port-level checks of the counting semaphore table, bound to the top level
`default_nettype none

module csem_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);
    import csem_pkg::*;

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result word changed while stalled");

    // one operation at a time: no word taken right after another
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an operation is in flight");

    // wake only on success, and wake_id is zero without wake
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3] ? (m_axis_tdata[2:0] == ST_OK)
                                           : (m_axis_tdata[19:4] == '0)))
        else $error("wake flag and status disagree");

    // failed operations other than saturation report a zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[2:0] == ST_BAD_VALUE
                           || m_axis_tdata[2:0] == ST_FULL
                           || m_axis_tdata[2:0] == ST_NOT_FOUND
                           || m_axis_tdata[2:0] == ST_WOULD_BLOCK))
        |-> (m_axis_tdata[34:20] == '0))
        else $error("nonzero count on a failed operation");

    // status code in range and padding zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] != 3'd6 && m_axis_tdata[2:0] != 3'd7
                           && m_axis_tdata[39:35] == '0))
        else $error("bad status code or padding");

endmodule : csem_checker

bind counting_semaphore_table_core csem_checker u_csem_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
